FILE: design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) \
		else $error("assertion failed");
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk_s, rst_n_s, prop)
`define ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons)
`endif

`endif

FILE: design/pkt_pkg.sv
// ----------------------------------------------------------------------------
// pkt_pkg
// Shared constants and types of the pressed key table.
// ----------------------------------------------------------------------------
package pkt_pkg;

	localparam int MAX_KEYS = 8;
	localparam int KEY_W    = 8;
	localparam int CHAR_W   = 16;
	localparam int OP_W     = 2;
	localparam int LEVEL_W  = 4;
	localparam int IDX_W    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int LVL_W    = $clog2(MAX_KEYS + 1);

	typedef enum logic [OP_W-1:0] {
		OP_KEY_DOWN = 2'd0,
		OP_KEY_UP   = 2'd1,
		OP_QUERY    = 2'd2,
		OP_CHAR     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_TRIM,
		ST_RESP
	} state_t;

endpackage

FILE: design/pkt_ram.sv
// ----------------------------------------------------------------------------
// pkt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pkt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: design/pressed_key_table_top.sv
// ----------------------------------------------------------------------------
// pressed_key_table_top
// Table of held key codes with fill level and last character code.
// ----------------------------------------------------------------------------
// Usage: drive op, scan_code and char_code with start high; the beat is taken
// at an edge where busy is low. busy then stays high until the result has been
// shown. The result (held, level, current_char) is on its ports for exactly
// one cycle with done high; the receiver cannot stall it.
// The key codes live in one RAM with a registered read. A key down or query
// walks the used entries from the top, one read issued per cycle with the
// compare in the cycle after it. A key up then walks again from the top to
// trim zero entries. A character event goes straight to the result. The
// entry walk runs through the single read port; one item is worked at a time.
// Reset clears the fill level, the held flag, the character and the sequencer; the RAM is
// not cleared, as entries above the level are never read before written.
// ----------------------------------------------------------------------------
module pressed_key_table_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          done,
	input  logic [pkt_pkg::OP_W-1:0]      op,
	input  logic [pkt_pkg::KEY_W-1:0]     scan_code,
	input  logic [pkt_pkg::CHAR_W-1:0]    char_code,
	output logic                          held,
	output logic [pkt_pkg::LEVEL_W-1:0]   level,
	output logic [pkt_pkg::CHAR_W-1:0]    current_char
);

`include "assert_macros.svh"

	pkt_pkg::state_t                state_q, state_d;
	pkt_pkg::op_t                   op_q;
	logic [pkt_pkg::KEY_W-1:0]      code_q, tgt_q;
	logic [pkt_pkg::LVL_W-1:0]      cnt_q, cnt_d;
	logic [pkt_pkg::LVL_W-1:0]      fill_q, fill_d;
	logic [pkt_pkg::CHAR_W-1:0]     char_q, char_d;
	logic                           held_q, held_d;
	logic                           pend_s1, pend_d;
	logic [pkt_pkg::IDX_W-1:0]      addr_s1;
	logic                           latch;

	logic                           rd_en, wr_en;
	logic [pkt_pkg::IDX_W-1:0]      rd_addr, wr_addr;
	logic [pkt_pkg::KEY_W-1:0]      wr_data, rd_data;
	logic                           issue, hit, full;

	pkt_ram #(
		.WIDTH(pkt_pkg::KEY_W),
		.DEPTH(pkt_pkg::MAX_KEYS)
	) u_entries (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign issue   = (cnt_q != '0);
	assign rd_addr = pkt_pkg::IDX_W'(cnt_q - 1'b1);
	assign full    = (fill_q >= pkt_pkg::LVL_W'(pkt_pkg::MAX_KEYS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pkt_pkg::ST_IDLE;
			cnt_q   <= '0;
			fill_q  <= '0;
			char_q  <= '0;
			held_q  <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			fill_q  <= fill_d;
			char_q  <= char_d;
			held_q  <= held_d;
			pend_s1 <= pend_d;
		end
	end

	// item payload and read address tracking
	always_ff @(posedge clk) begin
		if (latch) begin
			op_q   <= pkt_pkg::op_t'(op);
			code_q <= scan_code;
			// a full table looks for a zero hole on key down
			tgt_q  <= (pkt_pkg::op_t'(op) == pkt_pkg::OP_KEY_DOWN && full) ? '0 : scan_code;
		end
		addr_s1 <= rd_addr;
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		fill_d  = fill_q;
		char_d  = char_q;
		held_d  = held_q;
		pend_d  = 1'b0;
		latch   = 1'b0;
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = code_q;
		done    = 1'b0;
		hit     = pend_s1 && (rd_data == tgt_q);
		unique case (state_q)
			pkt_pkg::ST_IDLE: begin
				if (start) begin
					latch  = 1'b1;
					held_d = 1'b0;
					cnt_d  = fill_q;
					if (pkt_pkg::op_t'(op) == pkt_pkg::OP_CHAR) begin
						char_d  = char_code;
						state_d = pkt_pkg::ST_RESP;
					end else begin
						state_d = pkt_pkg::ST_SEARCH;
					end
				end
			end
			pkt_pkg::ST_SEARCH: begin
				rd_en  = issue;
				pend_d = issue;
				if (issue) begin
					cnt_d = cnt_q - 1'b1;
				end
				if (hit || !issue) begin
					pend_d  = 1'b0;
					cnt_d   = fill_q;
					state_d = pkt_pkg::ST_RESP;
					unique case (op_q)
						pkt_pkg::OP_KEY_DOWN: begin
							if (!full) begin
								if (!hit) begin
									wr_en   = 1'b1;
									wr_addr = pkt_pkg::IDX_W'(fill_q);
									fill_d  = pkt_pkg::LVL_W'(fill_q + 1'b1);
								end
							end else if (hit) begin
								wr_en = 1'b1;
							end
						end
						pkt_pkg::OP_KEY_UP: begin
							char_d  = '0;
							state_d = pkt_pkg::ST_TRIM;
							if (hit) begin
								wr_en   = 1'b1;
								wr_data = '0;
							end
						end
						pkt_pkg::OP_QUERY: begin
							held_d = hit && (code_q != '0);
						end
						pkt_pkg::OP_CHAR: begin
							held_d = 1'b0;
						end
						default: begin
							held_d = 1'b0;
						end
					endcase
				end
			end
			pkt_pkg::ST_TRIM: begin
				// reads run ahead; the first nonzero entry ends the walk
				rd_en  = issue;
				pend_d = issue;
				if (issue) begin
					cnt_d = cnt_q - 1'b1;
				end
				if (pend_s1) begin
					if (rd_data == '0) begin
						fill_d = fill_q - 1'b1;
					end else begin
						pend_d  = 1'b0;
						state_d = pkt_pkg::ST_RESP;
					end
				end else if (!issue) begin
					state_d = pkt_pkg::ST_RESP;
				end
			end
			pkt_pkg::ST_RESP: begin
				done    = 1'b1;
				state_d = pkt_pkg::ST_IDLE;
			end
			default: begin
				state_d = pkt_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy         = (state_q != pkt_pkg::ST_IDLE);
	assign held         = held_q;
	assign level        = pkt_pkg::LEVEL_W'(fill_q);
	assign current_char = char_q;

	`ASSERT_ALWAYS(a_fill_bound, clk, arst_n, fill_q <= pkt_pkg::LVL_W'(pkt_pkg::MAX_KEYS))
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done && !busy)
	`ASSERT_ALWAYS(a_keyup_char, clk, arst_n, !(done && op_q == pkt_pkg::OP_KEY_UP) || char_q == '0)
	`ASSERT_ALWAYS(a_held_query, clk, arst_n, !(done && held) || op_q == pkt_pkg::OP_QUERY)

endmodule
